/* hdl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg - shared definitions for the first-fit block allocator
// Action and status codes, reset arena size and the sequencer state type.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int ARENA_BITS  = 13;   // width of the arena size register
  localparam int SIZE_BITS   = 13;   // width of an allocate request
  localparam int OFFSET_BITS = 12;   // width of a payload offset
  localparam int ARENA_RESET = 4096; // arena size after reset

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOFIT = 1'b1;

  typedef enum logic [19:0] {
    S_IDLE      = 20'b0000_0000_0000_0000_0001,
    S_A_ROUND   = 20'b0000_0000_0000_0000_0010,
    S_A_CHK     = 20'b0000_0000_0000_0000_0100,
    S_A_RD      = 20'b0000_0000_0000_0000_1000,
    S_A_FIT     = 20'b0000_0000_0000_0001_0000,
    S_A_SPLIT   = 20'b0000_0000_0000_0010_0000,
    S_A_NH_ADDR = 20'b0000_0000_0000_0100_0000,
    S_A_NH_SIZE = 20'b0000_0000_0000_1000_0000,
    S_A_NH_WR   = 20'b0000_0000_0001_0000_0000,
    S_A_CUR_WR  = 20'b0000_0000_0010_0000_0000,
    S_A_TAKE    = 20'b0000_0000_0100_0000_0000,
    S_F_LO      = 20'b0000_0000_1000_0000_0000,
    S_F_HI      = 20'b0000_0001_0000_0000_0000,
    S_F_HDR     = 20'b0000_0010_0000_0000_0000,
    S_F_RD1     = 20'b0000_0100_0000_0000_0000,
    S_F_NEXT    = 20'b0000_1000_0000_0000_0000,
    S_F_RD2     = 20'b0001_0000_0000_0000_0000,
    S_F_MERGE   = 20'b0010_0000_0000_0000_0000,
    S_F_MARK    = 20'b0100_0000_0000_0000_0000,
    S_DONE      = 20'b1000_0000_0000_0000_0000
  } state_t;

endpackage

/* hdl/ffba_alu.sv */
// ----------------------------------------------------------------------------
// ffba_alu - shared add/subtract and compare unit
// r = a + b (or a - b); le flags r <= c; neg flags a negative difference.
// ----------------------------------------------------------------------------
module ffba_alu #(
  parameter int VW = 16
) (
  input  logic [VW-1:0] a,
  input  logic [VW-1:0] b,
  input  logic [VW-1:0] c,
  input  logic          sub,
  output logic [VW-1:0] r,
  output logic          le,
  output logic          neg
);

  logic [VW-1:0] b_eff;

  assign b_eff = sub ? ~b : b;
  assign r     = a + b_eff + {{(VW-1){1'b0}}, sub};
  assign le    = (r <= c);
  // operands stay well below the top bit, so the MSB is the borrow
  assign neg   = r[VW-1];

endmodule

/* hdl/ffba_hdr_ram.sv */
// ----------------------------------------------------------------------------
// ffba_hdr_ram - block header store
// One write port, one read port with registered read data; word = {free, size}.
// ----------------------------------------------------------------------------
module ffba_hdr_ram #(
  parameter int DEPTH = 4096,
  parameter int IW    = 12,
  parameter int DW    = 14
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator - first-fit allocator over a byte-offset arena
// Header store, one shared add/compare unit and the sequencer that drives it.
// ----------------------------------------------------------------------------
// A transaction on the command channel either allocates (action = 0) a block
// of req_size bytes, rounded up to 4, taking the first free block large enough
// and splitting it when the tail can hold a header plus 4 bytes, or frees
// (action = 1) the block at payload_offset, merging it with the next block
// when that one is free and inside the arena. Each command returns exactly one
// result transaction: status 0 with the payload offset (0 for a free), or
// status 1 (no fit). Commands are worked one at a time by a sequencer around
// a single adder and comparator and a header memory with one read and one
// write port. An allocate rounds the request, then for each header walked
// reads it and runs the bound and fit checks on the shared unit; a grant
// writes the header back, after a new split header when it splits, and a no
// fit ends with one more bound check instead. A free checks the offset bounds,
// reads its header and, when the next header lies inside the arena, that one
// too, then writes the merged or freed header. A result held off by res_stall
// holds the sequencer in its result state. The command channel stalls while a
// command is in flight. Writing arena_bytes (cfg_data) rebuilds the arena as
// one free block once idle after a write or reset; commands stall until done.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int ARENA_MAX_BYTES = 4096,
  parameter int HEADER_BYTES    = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write,
  input  logic [ffba_pkg::ARENA_BITS-1:0]  cfg_data,
  // command channel
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  logic                             action,
  input  logic [ffba_pkg::SIZE_BITS-1:0]   req_size,
  input  logic [ffba_pkg::OFFSET_BITS-1:0] payload_offset,
  // result channel
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic                             status,
  output logic [ffba_pkg::OFFSET_BITS-1:0] granted_offset
);

  import ffba_pkg::*;

  // header index, stored size and working value widths
  localparam int IW = $clog2(ARENA_MAX_BYTES);
  localparam int SW = $clog2(ARENA_MAX_BYTES + 1);
  localparam int VW = ((SW > SIZE_BITS + 1) ? SW : SIZE_BITS + 1) + 2;

  localparam logic [VW-1:0] HDR_V  = VW'(HEADER_BYTES);
  localparam logic [VW-1:0] HDR4_V = VW'(HEADER_BYTES + 4);
  localparam logic [VW-1:0] AMAX_V = VW'(ARENA_MAX_BYTES);
  localparam logic [VW-1:0] ROUND_V = VW'(3);
  localparam logic [SW-1:0] AMAX_S = SW'(ARENA_MAX_BYTES);
  localparam logic [SW-1:0] ARENA_RESET_S =
    SW'((ARENA_RESET > ARENA_MAX_BYTES) ? ARENA_MAX_BYTES : ARENA_RESET);

  state_t state, state_next;

  logic          init_pending;
  logic [SW-1:0] arena;
  logic [VW-1:0] arena_v;
  logic [VW-1:0] cfg_v;

  // command and walk registers
  logic [VW-1:0] req_v;     // requested size
  logic [VW-1:0] poff;      // payload offset to free
  logic [VW-1:0] want;      // rounded request
  logic [VW-1:0] cur;       // current header offset
  logic [VW-1:0] pay;       // its payload offset
  logic [VW-1:0] nxt;       // next header, or new split header
  logic [VW-1:0] tmp;
  logic [VW-1:0] hdr;       // header being freed
  logic [SW-1:0] blk_size;
  logic          blk_free;

  logic          done_status;
  logic [OFFSET_BITS-1:0] done_offset;

  // shared unit
  logic [VW-1:0] alu_a, alu_b, alu_c, alu_r;
  logic          alu_sub, alu_le, alu_neg;

  // header store
  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [SW:0]   wr_data, rd_data;
  logic          rd_free;
  logic [SW-1:0] rd_size;
  logic [VW-1:0] rd_size_v, blk_size_v;

  logic          cmd_take;
  logic          res_free;

  assign rd_free    = rd_data[SW];
  assign rd_size    = rd_data[SW-1:0];
  assign rd_size_v  = {{(VW-SW){1'b0}}, rd_size};
  assign blk_size_v = {{(VW-SW){1'b0}}, blk_size};
  assign arena_v    = {{(VW-SW){1'b0}}, arena};
  assign cfg_v      = {{(VW-ARENA_BITS){1'b0}}, cfg_data};

  assign cmd_stall = (state != S_IDLE) || init_pending;
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign res_free  = !res_valid || !res_stall;

  ffba_alu #(.VW(VW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .sub (alu_sub),
    .r   (alu_r),
    .le  (alu_le),
    .neg (alu_neg)
  );

  ffba_hdr_ram #(.DEPTH(ARENA_MAX_BYTES), .IW(IW), .DW(SW + 1)) u_hdr_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // operand select, memory control and next state
  always_comb begin
    alu_a      = '0;
    alu_b      = '0;
    alu_c      = '0;
    alu_sub    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        // arena rebuild: entry 0 gets arena - header, when the arena holds one
        alu_a   = arena_v;
        alu_b   = HDR_V;
        alu_sub = 1'b1;
        wr_en   = init_pending && !alu_neg;
        wr_data = {1'b1, alu_r[SW-1:0]};
        if (cmd_take) begin
          state_next = (action == ACT_FREE) ? S_F_LO : S_A_ROUND;
        end
      end
      S_A_ROUND: begin
        alu_a      = req_v;
        alu_b      = ROUND_V;
        state_next = S_A_CHK;
      end
      S_A_CHK: begin
        // header must fit before the arena end
        alu_a   = cur;
        alu_b   = HDR_V;
        alu_c   = arena_v;
        rd_en   = alu_le;
        rd_addr = cur[IW-1:0];
        state_next = alu_le ? S_A_RD : S_DONE;
      end
      S_A_RD: begin
        // payload must fit too, else the chain is broken
        alu_a = pay;
        alu_b = rd_size_v;
        alu_c = arena_v;
        state_next = alu_le ? S_A_FIT : S_DONE;
      end
      S_A_FIT: begin
        alu_a = want;
        alu_c = blk_size_v;
        state_next = (blk_free && alu_le) ? S_A_SPLIT : S_A_CHK;
      end
      S_A_SPLIT: begin
        alu_a = want;
        alu_b = HDR4_V;
        alu_c = blk_size_v;
        state_next = alu_le ? S_A_NH_ADDR : S_A_TAKE;
      end
      S_A_NH_ADDR: begin
        alu_a      = pay;
        alu_b      = want;
        state_next = S_A_NH_SIZE;
      end
      S_A_NH_SIZE: begin
        alu_a      = blk_size_v;
        alu_b      = want;
        alu_sub    = 1'b1;
        state_next = S_A_NH_WR;
      end
      S_A_NH_WR: begin
        alu_a      = tmp;
        alu_b      = HDR_V;
        alu_sub    = 1'b1;
        wr_en      = 1'b1;
        wr_addr    = nxt[IW-1:0];
        wr_data    = {1'b1, alu_r[SW-1:0]};
        state_next = S_A_CUR_WR;
      end
      S_A_CUR_WR: begin
        wr_en      = 1'b1;
        wr_addr    = cur[IW-1:0];
        wr_data    = {1'b0, want[SW-1:0]};
        state_next = S_DONE;
      end
      S_A_TAKE: begin
        wr_en      = 1'b1;
        wr_addr    = cur[IW-1:0];
        wr_data    = {1'b0, blk_size};
        state_next = S_DONE;
      end
      S_F_LO: begin
        alu_a = HDR_V;
        alu_c = poff;
        state_next = alu_le ? S_F_HI : S_DONE;
      end
      S_F_HI: begin
        alu_a = poff;
        alu_c = arena_v;
        state_next = alu_le ? S_F_HDR : S_DONE;
      end
      S_F_HDR: begin
        alu_a      = poff;
        alu_b      = HDR_V;
        alu_sub    = 1'b1;
        rd_en      = 1'b1;
        rd_addr    = alu_r[IW-1:0];
        state_next = S_F_RD1;
      end
      S_F_RD1: begin
        alu_a      = poff;
        alu_b      = rd_size_v;
        state_next = S_F_NEXT;
      end
      S_F_NEXT: begin
        // merge only with a header that lies inside the arena
        alu_a   = nxt;
        alu_b   = HDR_V;
        alu_c   = arena_v;
        rd_en   = alu_le;
        rd_addr = nxt[IW-1:0];
        state_next = alu_le ? S_F_RD2 : S_F_MARK;
      end
      S_F_RD2: begin
        alu_a      = blk_size_v;
        alu_b      = HDR_V;
        state_next = rd_free ? S_F_MERGE : S_F_MARK;
      end
      S_F_MERGE: begin
        // merged size saturates at the arena maximum
        alu_a      = tmp;
        alu_b      = rd_size_v;
        alu_c      = AMAX_V;
        wr_en      = 1'b1;
        wr_addr    = hdr[IW-1:0];
        wr_data    = {1'b1, alu_le ? alu_r[SW-1:0] : AMAX_S};
        state_next = S_DONE;
      end
      S_F_MARK: begin
        wr_en      = 1'b1;
        wr_addr    = hdr[IW-1:0];
        wr_data    = {1'b1, blk_size};
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      init_pending <= 1'b1;
      arena        <= ARENA_RESET_S;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        arena        <= (cfg_v > AMAX_V) ? AMAX_S : cfg_v[SW-1:0];
        init_pending <= 1'b1;
      end else if (state == S_IDLE) begin
        init_pending <= 1'b0;
      end
      if (state == S_DONE && res_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result register: loads only when the slot is free
  always_ff @(posedge clk) begin
    if (state == S_DONE && res_free) begin
      status         <= done_status;
      granted_offset <= done_offset;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (cmd_take) begin
          req_v       <= {{(VW-SIZE_BITS){1'b0}}, req_size};
          poff        <= {{(VW-OFFSET_BITS){1'b0}}, payload_offset};
          cur         <= '0;
          done_status <= STATUS_OK;
          done_offset <= '0;
        end
      end
      S_A_ROUND: begin
        want <= {alu_r[VW-1:2], 2'b00};
      end
      S_A_CHK: begin
        pay <= alu_r;
        if (!alu_le) begin
          done_status <= STATUS_NOFIT;
        end
      end
      S_A_RD: begin
        nxt      <= alu_r;
        blk_size <= rd_size;
        blk_free <= rd_free;
        if (!alu_le) begin
          done_status <= STATUS_NOFIT;
        end
      end
      S_A_FIT: begin
        if (!(blk_free && alu_le)) begin
          cur <= nxt;
        end
      end
      S_A_SPLIT: begin
      end
      S_A_NH_ADDR: begin
        nxt <= alu_r;
      end
      S_A_NH_SIZE: begin
        tmp <= alu_r;
      end
      S_A_NH_WR: begin
      end
      S_A_CUR_WR, S_A_TAKE: begin
        done_offset <= pay[OFFSET_BITS-1:0];
      end
      S_F_LO, S_F_HI: begin
      end
      S_F_HDR: begin
        hdr <= alu_r;
      end
      S_F_RD1: begin
        blk_size <= rd_size;
        nxt      <= alu_r;
      end
      S_F_NEXT: begin
      end
      S_F_RD2: begin
        tmp <= alu_r;
      end
      S_F_MERGE, S_F_MARK, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

/* sim/first_fit_block_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb - self-checking bench for the first-fit allocator
// Commands go from a queue of pending transactions through a clocked driver.
// Each accepted command updates a behavioural copy of the header store, and
// that copy gives the result this command should return. A clocked monitor
// checks every result transaction against the oldest prediction. A short
// directed sequence comes first. Then randomised phases follow, each under
// its own arena size and one of four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int ARENA_MAX_BYTES = 4096;
  localparam int HEADER_BYTES    = 16;
  localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES   = 8;     // quiet cycles before a register write
  localparam int DRAIN_CYCLES    = 40;    // quiet cycles after the last result
  // Slowest legal run: 589 commands, each walking up to 256 headers, plus a
  // stalled result and sender gaps.
  localparam int CYCLE_LIMIT     = 4_000_000;

  // How the offset of a free command is chosen. This happens when the driver
  // picks the command up, so it sees every earlier command already applied.
  typedef enum logic [1:0] {PICK_FIXED, PICK_LIVE, PICK_ANY} offset_pick_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                   act;
    logic [SIZE_BITS-1:0]   size;
    logic [OFFSET_BITS-1:0] offset;
    offset_pick_t           pick;
  } cmd_intent_t;

  typedef struct packed {
    logic                   status;
    logic [OFFSET_BITS-1:0] offset;
  } outcome_t;

  // DUT inputs: known values from time zero
  logic                   clk            = 1'b0;
  logic                   rst            = 1'b1;
  logic                   cfg_write      = 1'b0;
  logic [ARENA_BITS-1:0]  cfg_data       = '0;
  logic                   cmd_valid      = 1'b0;
  logic                   action         = ACT_ALLOC;
  logic [SIZE_BITS-1:0]   req_size       = '0;
  logic [OFFSET_BITS-1:0] payload_offset = '0;
  logic                   res_stall      = 1'b0;
  // DUT outputs
  logic                   cmd_stall;
  logic                   res_valid;
  logic                   status;
  logic [OFFSET_BITS-1:0] granted_offset;

  // Behavioural header store. It is indexed by the byte offset of the header
  // and tracks which entries have ever been written.
  bit          blk_free [0:ARENA_MAX_BYTES-1];
  int unsigned blk_len  [0:ARENA_MAX_BYTES-1];
  bit          blk_seen [0:ARENA_MAX_BYTES-1];
  int unsigned arena_len;
  int unsigned live_blocks[$];       // payload offsets handed out and not yet freed

  cmd_intent_t pending_cmds[$];
  outcome_t    outcome_q[$];
  idle_mode_t  idle_mode     = IDLE_NONE;
  int          cmds_issued   = 0;
  int          cmds_accepted = 0;
  int          hold_requests = 0;
  int          hold_seen     = 0;
  int          hold_cnt      = 0;
  int          cycle_count   = 0;
  int          errors        = 0;
  int          n_results     = 0;
  int          n_allocs      = 0;
  int          n_frees       = 0;
  int          n_nofits      = 0;
  int          n_splits      = 0;
  int          n_merges      = 0;
  int          n_arenas      = 0;

  first_fit_block_allocator #(
    .ARENA_MAX_BYTES (ARENA_MAX_BYTES),
    .HEADER_BYTES    (HEADER_BYTES)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .action         (action),
    .req_size       (req_size),
    .payload_offset (payload_offset),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .status         (status),
    .granted_offset (granted_offset)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioural allocator
  // --------------------------------------------------------------------------

  // Register write: the arena becomes a single free block. Sizes above the
  // maximum are clamped. An arena smaller than one header holds no block.
  function automatic void rebuild_arena(input int unsigned v);
    int unsigned a;
    a = v & 32'h1FFF;
    if (a > ARENA_MAX_BYTES) a = ARENA_MAX_BYTES;
    arena_len = a;
    if (a >= HEADER_BYTES) begin
      blk_free[0] = 1'b1;
      blk_len[0]  = a - HEADER_BYTES;
      blk_seen[0] = 1'b1;
    end
    live_blocks.delete();
  endfunction

  // Walk the chain from offset 0 and take the first free block big enough.
  // Split it when the tail can hold a header plus 4 bytes.
  function automatic void alloc_first_fit(input int unsigned req,
                                          output logic st,
                                          output logic [OFFSET_BITS-1:0] off);
    int unsigned want, cur, sz, pay, nh;
    bit walking;
    want    = (req + 3) & ~32'd3;
    cur     = 0;
    walking = 1'b1;
    st      = STATUS_NOFIT;
    off     = '0;
    while (walking && cur + HEADER_BYTES <= arena_len) begin
      sz  = blk_len[cur];
      pay = cur + HEADER_BYTES;
      if (pay + sz > arena_len) begin
        walking = 1'b0;                 // chain runs past the arena end
      end else if (blk_free[cur] && sz >= want) begin
        if (sz >= want + HEADER_BYTES + 4) begin
          nh           = pay + want;
          blk_free[nh] = 1'b1;
          blk_len[nh]  = sz - HEADER_BYTES - want;
          blk_seen[nh] = 1'b1;
          blk_len[cur] = want;
          n_splits++;
        end
        blk_free[cur] = 1'b0;
        st            = STATUS_OK;
        off           = pay[OFFSET_BITS-1:0];
        walking       = 1'b0;
      end else begin
        cur = pay + sz;
      end
    end
  endfunction

  // Mark a block free and absorb the next block when it is free and lies in
  // the arena. Offsets below a header or past the arena are ignored.
  function automatic void release_block(input int unsigned p);
    int unsigned h, n, merged;
    if (p >= HEADER_BYTES && p <= arena_len) begin
      h = p - HEADER_BYTES;
      n = p + blk_len[h];
      if (n + HEADER_BYTES <= arena_len && blk_free[n]) begin
        merged = blk_len[h] + HEADER_BYTES + blk_len[n];
        if (merged > ARENA_MAX_BYTES) merged = ARENA_MAX_BYTES;
        blk_len[h] = merged;
        n_merges++;
      end
      blk_free[h] = 1'b1;
    end
  endfunction

  // True when freeing p touches no header entry that was never written.
  function automatic bit free_reads_known(input int unsigned p);
    int unsigned h, n;
    if (p < HEADER_BYTES || p > arena_len) return 1'b1;
    h = p - HEADER_BYTES;
    if (!blk_seen[h]) return 1'b0;
    n = p + blk_len[h];
    if (n + HEADER_BYTES <= arena_len && !blk_seen[n]) return 1'b0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Idle patterns
  // --------------------------------------------------------------------------

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 85;
      IDLE_BOTH:   return $urandom_range(99) < 15;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_rests();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 85;
      IDLE_BOTH:     return $urandom_range(99) < 15;
      default:       return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Command driver: a new transaction is offered only once the previous one
  // has been accepted, so the payload stays put for as long as it is stalled.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : cmd_driver
    cmd_intent_t it;
    int unsigned p;
    int          idx;
    int          tries;
    if (!rst && cmds_issued == cmds_accepted) begin
      if (pending_cmds.size() == 0 || sender_rests()) begin
        cmd_valid <= 1'b0;
      end else begin
        it = pending_cmds.pop_front();
        p  = it.offset;
        if (it.act == ACT_FREE) begin
          if (it.pick == PICK_LIVE && live_blocks.size() != 0) begin
            p = live_blocks[$urandom_range(live_blocks.size() - 1)];
          end else if (it.pick == PICK_ANY) begin
            tries = 0;
            p     = $urandom_range(ARENA_MAX_BYTES - 1);
            while (!free_reads_known(p) && tries < 8) begin
              p = $urandom_range(ARENA_MAX_BYTES - 1);
              if ($urandom_range(1)) p = p & ~32'd3;   // aligned: likely a header
              tries++;
            end
          end
          // never touch a header that has not been written: fall back to an
          // offset below the first payload, which the block must ignore
          if (!free_reads_known(p)) p = $urandom_range(HEADER_BYTES - 1);
          for (idx = live_blocks.size() - 1; idx >= 0; idx--) begin
            if (live_blocks[idx] == p) live_blocks.delete(idx);
          end
        end
        action         <= it.act;
        req_size       <= it.size;
        payload_offset <= p[OFFSET_BITS-1:0];
        cmd_valid      <= 1'b1;
        cmds_issued++;
      end
    end
  end

  // Each accepted command is applied to the behavioural store at once, giving
  // the result it must produce.
  always @(posedge clk) begin : cmd_accept
    outcome_t               r;
    logic                   st;
    logic [OFFSET_BITS-1:0] off;
    if (!rst && cmd_valid && !cmd_stall) begin
      if (action == ACT_FREE) begin
        release_block(payload_offset);
        st  = STATUS_OK;
        off = '0;
        n_frees++;
      end else begin
        alloc_first_fit(req_size, st, off);
        n_allocs++;
        if (st == STATUS_NOFIT) n_nofits++;
        else live_blocks.push_back(off);
      end
      r.status = st;
      r.offset = off;
      outcome_q.push_back(r);
      cmds_accepted++;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus a long hold-off that it times itself
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : result_sink
    if (hold_cnt != 0) begin
      hold_cnt--;
      res_stall <= 1'b1;
    end else if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_cnt  = HOLD_CYCLES - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= receiver_rests();
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t want_r;
    if (!rst && res_valid && !res_stall) begin
      n_results++;
      if (outcome_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result: status %0d offset %0d",
                   $realtime, status, granted_offset);
      end else begin
        want_r = outcome_q.pop_front();
        if (status !== want_r.status || granted_offset !== want_r.offset) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result %0d: expected status %0d offset %0d, got status %0d offset %0d",
                     $realtime, n_results, want_r.status, want_r.offset,
                     status, granted_offset);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, outcome_q.size());
      $display("first_fit_block_allocator_tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic queue_cmd(input logic act, input int unsigned size,
                           input int unsigned offset, input offset_pick_t pick);
    cmd_intent_t it;
    it.act    = act;
    it.size   = size[SIZE_BITS-1:0];
    it.offset = offset[OFFSET_BITS-1:0];
    it.pick   = pick;
    pending_cmds.push_back(it);
  endtask

  // Block is idle once nothing is queued, in flight or outstanding.
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmds_issued != cmds_accepted ||
           outcome_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_arena(input int unsigned v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data  <= v[ARENA_BITS-1:0];
    cfg_write <= 1'b1;
    rebuild_arena(v);
    n_arenas++;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly allocates and frees of live blocks; some frees hit arbitrary or
  // bad offsets. Unused fields carry random bits.
  task automatic queue_random(input int n);
    int i, r, s;
    int unsigned size;
    for (i = 0; i < n; i++) begin
      if (i == n / 2) wait_drained();       // sender pauses until all results are back
      r = $urandom_range(99);
      if (r < 55) begin
        s = $urandom_range(99);
        if (s < 30)      size = $urandom_range(16);
        else if (s < 65) size = $urandom_range(128, 17);
        else if (s < 85) size = $urandom_range(1024, 129);
        else if (s < 95) size = $urandom_range(4096, 1025);
        else             size = $urandom_range(8191, 4097);
        queue_cmd(ACT_ALLOC, size, $urandom_range(4095), PICK_FIXED);
      end else begin
        s = $urandom_range(99);
        queue_cmd(ACT_FREE, $urandom_range(8191), $urandom_range(HEADER_BYTES - 1),
                  s < 75 ? PICK_LIVE : (s < 90 ? PICK_ANY : PICK_FIXED));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase_arena[12];
    int          phase_items[12];
    int          ph;
    rebuild_arena(ARENA_RESET);
    n_arenas = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, on the reset arena: zero request, rounding, no fit at the
    // largest request, bad offsets, merges, an exact fit and the split bound.
    queue_cmd(ACT_ALLOC, 0,    12'hFFF, PICK_FIXED);   // zero-byte block at 16
    queue_cmd(ACT_ALLOC, 1,    0,       PICK_FIXED);   // rounds to 4, at 32
    queue_cmd(ACT_ALLOC, 3,    0,       PICK_FIXED);   // at 52
    queue_cmd(ACT_ALLOC, 4096, 0,       PICK_FIXED);   // no fit
    queue_cmd(ACT_ALLOC, 8191, 12'hFFF, PICK_FIXED);   // no fit, widest request
    queue_cmd(ACT_FREE,  8191, 0,       PICK_FIXED);   // below first payload
    queue_cmd(ACT_FREE,  0,    15,      PICK_FIXED);   // below first payload
    queue_cmd(ACT_FREE,  8191, 32,      PICK_FIXED);   // next block busy: no merge
    queue_cmd(ACT_FREE,  0,    52,      PICK_FIXED);   // merges with the tail
    queue_cmd(ACT_FREE,  0,    32,      PICK_FIXED);   // free again, merges
    queue_cmd(ACT_FREE,  0,    16,      PICK_FIXED);   // whole arena free again
    queue_cmd(ACT_ALLOC, 4080, 12'hFFF, PICK_FIXED);   // exact fit
    queue_cmd(ACT_ALLOC, 0,    0,       PICK_FIXED);   // nothing left
    queue_cmd(ACT_FREE,  0,    16,      PICK_FIXED);   // next block past arena end
    queue_cmd(ACT_ALLOC, 4077, 0,       PICK_FIXED);   // rounds to the whole arena
    queue_cmd(ACT_FREE,  0,    16,      PICK_FIXED);
    queue_cmd(ACT_ALLOC, 4061, 0,       PICK_FIXED);   // tail too small to split
    queue_cmd(ACT_FREE,  0,    16,      PICK_FIXED);
    queue_cmd(ACT_ALLOC, 4060, 0,       PICK_FIXED);   // tail of exactly one header plus 4 bytes
    queue_cmd(ACT_FREE,  0,    16,      PICK_FIXED);   // merges the small tail block
    queue_cmd(ACT_ALLOC, 2,    0,       PICK_FIXED);
    queue_cmd(ACT_FREE,  0,    16,      PICK_FIXED);
    wait_drained();

    // Arena sizes: clamped maximum, arenas smaller than one header, a single
    // tiny block, the smallest usable arena, then ordinary and random sizes.
    phase_arena = '{8191, 0, 15, 16, 20, 64, 4096, 512, 0, 256, 2048, 0};
    phase_items = '{70, 8, 8, 8, 8, 20, 80, 80, 75, 70, 80, 60};
    phase_arena[8]  = $urandom_range(4095, 65);
    phase_arena[11] = $urandom_range(400, 21);
    for (ph = 0; ph < 12; ph++) begin
      write_arena(phase_arena[ph]);
      idle_mode = idle_mode_t'(ph % 4);
      if (ph == 0) hold_requests++;          // block fills and stalls its input
      queue_random(phase_items[ph]);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d commands (%0d allocates, %0d frees) over %0d arena sizes, %0d results checked",
             cmds_accepted, n_allocs, n_frees, n_arenas, n_results);
    $display("%0d no-fit answers, %0d splits, %0d merges, %0d mismatches",
             n_nofits, n_splits, n_merges, errors);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("first_fit_block_allocator_tb: clean");
    end else begin
      $display("first_fit_block_allocator_tb: errors");
    end
    $finish;
  end

endmodule
